// File: src/bisf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary image shape finder.
// No dependencies; the top level imports this package.
package bisf_pkg;
	localparam int DEF_MAX_DIM = 64;
	localparam int DIM_W = 7;
	localparam int CRD_W = 6;
	localparam int LEN_W = 7;

	typedef enum logic [1:0] {
		MODE_HORIZ  = 2'd0,
		MODE_VERT   = 2'd1,
		MODE_SQUARE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RUNS_RD,
		ST_RUNS_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SQ_RD,
		ST_SQ_CHK,
		ST_OUT
	} state_t;
endpackage

// File: src/bisf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bisf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/binary_image_shape_finder_top.sv
`timescale 1ns / 1ps
// Top level of the binary image shape finder: sequencer, run builder and search.
// Depends on bisf_pkg and bisf_ram.
//
// Usage: cells arrive on the cell request channel (cell_bit, valid/ready) in
// row-major order, one per cycle while loading. Configuration (image_rows,
// image_cols, search_mode) is written through cfg_we/cfg_idx/cfg_data between
// bitmaps, while no cell of a bitmap has been taken yet. When the last cell of
// the bitmap is accepted, ready drops and the block runs its search, then
// offers one result request on the output channel (valid/ready).
// The search first builds the right and down run lengths of every cell of the
// rows x cols bitmap, walking the store backward with a read state and a write
// state per cell, and then scans forward with a read state and a check state
// per cell. In the square search a cell that can still beat the best square
// also reads and checks its bottom-left and then its top-right corner for each
// side tried, starting from the largest side its own runs and the bitmap edges
// allow. With the undefined mode the result is valid in the cycle after the
// last cell is accepted. Each memory has a single read port.
// The result register holds its request while the receiver stalls, and the
// next bitmap is taken from the cycle after the result is accepted.
// Reset clears the cell count and the sequencer; memory contents are not
// cleared, as every cell read by a search has been written for that bitmap.
module binary_image_shape_finder_top
	import bisf_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cell_bit,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             shape_found,
	output logic [CRD_W-1:0] start_row,
	output logic [CRD_W-1:0] start_col,
	output logic [CRD_W-1:0] end_row,
	output logic [CRD_W-1:0] end_col,
	output logic [LEN_W-1:0] shape_length
);
	localparam int CW = $clog2(MAX_DIM);            // coordinate width
	localparam int AW = 2 * CW;                       // address width
	localparam int DEPTH = 1 << AW;
	localparam int RW = $clog2(MAX_DIM + 1);          // run length width
	localparam int DW = $clog2(MAX_DIM + 1);          // dimension width

	// Configuration registers.
	logic [DIM_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [1:0]       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_W'(64);
			cols_cfg_q <= DIM_W'(64);
			mode_q     <= MODE_HORIZ;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROWS: rows_cfg_q <= cfg_data;
				REG_COLS: cols_cfg_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions to 1..MAX_DIM.
	logic [DW-1:0] rows, cols;
	always_comb begin
		if (rows_cfg_q == '0) rows = DW'(1);
		else if (32'(rows_cfg_q) > MAX_DIM) rows = DW'(MAX_DIM);
		else rows = DW'(rows_cfg_q);
		if (cols_cfg_q == '0) cols = DW'(1);
		else if (32'(cols_cfg_q) > MAX_DIM) cols = DW'(MAX_DIM);
		else cols = DW'(cols_cfg_q);
	end

	// Sequencer state.
	state_t state_q, state_d;
	logic [DW-1:0] r_q, c_q;          // walk position
	logic [DW-1:0] rt_q, ct_q;        // load position within current dims
	logic [RW-1:0] side_q;            // candidate side in the square search
	logic          px_cur_q;          // pixel of the previous scan cell
	logic          prev_px_q;         // left or upper neighbor pixel
	logic [LEN_W-1:0] best_len_q;
	logic [CW-1:0] br0_q, bc0_q, br1_q, bc1_q;
	logic [RW-1:0] next_rr_q;         // run right of the cell to the right
	logic [RW-1:0] bl_rr_q;           // run right of the bottom-left corner
	logic          sub_q;             // 0 reads bottom-left, 1 reads top-right
	logic [MAX_DIM-1:0] above_q;      // pixel of the previous row per column
	logic          last_load;
	logic          cell_adv;

	// Memories: image bits, and a packed {run_right, run_down} per cell.
	logic          img_we;
	logic [AW-1:0] img_waddr, img_raddr;
	logic          img_wdata, img_rdata;
	logic          run_we;
	logic [AW-1:0] run_waddr, run_raddr;
	logic [2*RW-1:0] run_wdata, run_rdata;
	// Down runs of the row below for the builder, kept per column.
	logic [RW-1:0] dn_wdata, dn_rdata;
	logic [CW-1:0] dn_raddr;

	bisf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_img (
		.clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
		.raddr(img_raddr), .rdata(img_rdata)
	);
	bisf_ram #(.WIDTH(2 * RW), .DEPTH(DEPTH)) u_run (
		.clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
		.raddr(run_raddr), .rdata(run_rdata)
	);
	bisf_ram #(.WIDTH(RW), .DEPTH(MAX_DIM)) u_dn (
		.clk(clk), .we(run_we), .waddr(c_q[CW-1:0]), .wdata(dn_wdata),
		.raddr(dn_raddr), .rdata(dn_rdata)
	);

	function automatic logic [AW-1:0] addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
		addr = {r[CW-1:0], c[CW-1:0]};
	endfunction

	// Loading: wrap row/col within current dims; cell stored only if in range.
	logic in_range;
	assign in_range = (rt_q < rows) && (ct_q < cols);
	assign last_load = (rt_q >= rows - DW'(1)) && ((ct_q >= cols - DW'(1)) || (rt_q >= rows));

	// Builder: at (r_q,c_q) reading pixel; dn from RAM u_dn = down run of row below.
	logic [RW-1:0] rr_new, rd_new;
	always_comb begin
		rr_new = '0;
		rd_new = '0;
		if (img_rdata) begin
			rr_new = RW'(1) + ((c_q + DW'(1) < cols) ? next_rr_q : RW'(0));
			rd_new = RW'(1) + ((r_q + DW'(1) < rows) ? dn_rdata : RW'(0));
		end
	end
	assign dn_wdata  = rd_new;
	assign run_wdata = {rr_new, rd_new};
	assign dn_raddr  = c_q[CW-1:0];

	// Runs read back from the run memory.
	logic [RW-1:0] rd_right, rd_down;
	assign rd_right = run_rdata[2*RW-1:RW];
	assign rd_down  = run_rdata[RW-1:0];

	// Square limit from the bitmap edges.
	logic [DW:0] lim;
	always_comb begin
		logic [DW:0] lr, lc;
		lr = (DW+1)'(rows) - (DW+1)'(r_q);
		lc = (DW+1)'(cols) - (DW+1)'(c_q);
		lim = (lc < lr) ? lc : lr;
	end

	// The first side worth trying is bounded by the cell's own runs as well,
	// since its top and left edges must be set over the whole side.
	logic [DW:0] sq_start;
	always_comb begin
		sq_start = lim;
		if ((DW+1)'(rd_right) < sq_start) sq_start = (DW+1)'(rd_right);
		if ((DW+1)'(rd_down) < sq_start) sq_start = (DW+1)'(rd_down);
	end
	logic sq_go;
	assign sq_go = (mode_q == MODE_SQUARE) && img_rdata && (sq_start >= (DW+1)'(2)) &&
		(sq_start > (DW+1)'(best_len_q));

	logic [DW-1:0] far;
	assign far = DW'(side_q) - DW'(1);
	logic [RW-1:0] side_dn;
	assign side_dn = side_q - RW'(1);
	logic sq_hit, sq_more;
	assign sq_hit  = (bl_rr_q >= side_q) && (rd_down >= side_q);
	assign sq_more = (side_dn >= RW'(2)) &&
		((LEN_W+1)'(side_dn) > (LEN_W+1)'(best_len_q));

	logic last_cell;
	assign last_cell = (r_q == rows - DW'(1)) && (c_q == cols - DW'(1));

	always_comb begin
		state_d   = state_q;
		img_we    = 1'b0;
		img_waddr = addr(rt_q, ct_q);
		img_wdata = cell_bit;
		img_raddr = addr(r_q, c_q);
		run_we    = 1'b0;
		run_waddr = addr(r_q, c_q);
		run_raddr = addr(r_q, c_q);
		in_ready  = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OUT);
		cell_adv  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				img_we = in_valid && in_range;
				if (in_valid && last_load) state_d = (mode_q == MODE_NONE) ? ST_OUT
					: ST_RUNS_RD;
			end
			ST_RUNS_RD: state_d = ST_RUNS_WR;
			ST_RUNS_WR: begin
				run_we = 1'b1;
				state_d = (r_q == '0 && c_q == '0) ? ST_SCAN_RD : ST_RUNS_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (sq_go) begin
					state_d = ST_SQ_RD;
				end else begin
					cell_adv = 1'b1;
					state_d  = last_cell ? ST_OUT : ST_SCAN_RD;
				end
			end
			ST_SQ_RD: begin
				run_raddr = sub_q ? addr(r_q, c_q + far) : addr(r_q + far, c_q);
				state_d = ST_SQ_CHK;
			end
			ST_SQ_CHK: begin
				if (!sub_q || (!sq_hit && sq_more)) begin
					state_d = ST_SQ_RD;
				end else begin
					cell_adv = 1'b1;
					state_d  = last_cell ? ST_OUT : ST_SCAN_RD;
				end
			end
			ST_OUT: if (out_ready) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// Datapath registers. The scan reads the pixel and runs of (r_q,c_q);
	// prev_px_q holds the neighbor pixel (left for mode 0, above for mode 1),
	// taken from the previous cell's pixel or from the per-column copy of the
	// row above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			rt_q       <= '0;
			ct_q       <= '0;
			r_q        <= '0;
			c_q        <= '0;
			best_len_q <= '0;
			sub_q      <= 1'b0;
			side_q     <= '0;
			px_cur_q   <= 1'b0;
			prev_px_q  <= 1'b0;
			next_rr_q  <= '0;
			bl_rr_q    <= '0;
			above_q    <= '0;
			br0_q      <= '0;
			bc0_q      <= '0;
			br1_q      <= '0;
			bc1_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (in_valid) begin
					if (last_load) begin
						rt_q <= '0;
						ct_q <= '0;
						r_q  <= rows - DW'(1);
						c_q  <= cols - DW'(1);
						best_len_q <= '0;
					end else if (ct_q + DW'(1) >= cols) begin
						ct_q <= '0;
						rt_q <= rt_q + DW'(1);
					end else begin
						ct_q <= ct_q + DW'(1);
					end
				end
				ST_RUNS_WR: begin
					next_rr_q <= rr_new;
					if (c_q == '0) begin
						if (r_q != '0) begin
							c_q <= cols - DW'(1);
							r_q <= r_q - DW'(1);
						end
					end else c_q <= c_q - DW'(1);
				end
				ST_SCAN_RD: begin
					prev_px_q <= (mode_q == MODE_HORIZ) ? ((c_q != '0) && px_cur_q)
						: ((r_q != '0) && above_q[c_q[CW-1:0]]);
				end
				ST_SCAN_CHK: begin
					px_cur_q <= img_rdata;
					above_q[c_q[CW-1:0]] <= img_rdata;
					if (sq_go) begin
						side_q <= RW'(sq_start);
						sub_q  <= 1'b0;
					end else if (mode_q == MODE_HORIZ && img_rdata && !prev_px_q &&
						LEN_W'(rd_right) > best_len_q) begin
						best_len_q <= LEN_W'(rd_right);
						br0_q <= r_q[CW-1:0]; bc0_q <= c_q[CW-1:0];
						br1_q <= r_q[CW-1:0];
						bc1_q <= CW'(c_q + DW'(rd_right) - DW'(1));
					end else if (mode_q == MODE_VERT && img_rdata && !prev_px_q &&
						LEN_W'(rd_down) > best_len_q) begin
						best_len_q <= LEN_W'(rd_down);
						br0_q <= r_q[CW-1:0]; bc0_q <= c_q[CW-1:0];
						br1_q <= CW'(r_q + DW'(rd_down) - DW'(1));
						bc1_q <= c_q[CW-1:0];
					end
					if (cell_adv) begin
						if (c_q + DW'(1) >= cols) begin
							c_q <= '0;
							r_q <= r_q + DW'(1);
						end else c_q <= c_q + DW'(1);
					end
				end
				ST_SQ_CHK: begin
					if (!sub_q) begin
						bl_rr_q <= rd_right;
						sub_q   <= 1'b1;
					end else begin
						sub_q <= 1'b0;
						if (sq_hit) begin
							best_len_q <= LEN_W'(side_q);
							br0_q <= r_q[CW-1:0]; bc0_q <= c_q[CW-1:0];
							br1_q <= CW'(r_q + far); bc1_q <= CW'(c_q + far);
						end else side_q <= side_dn;
					end
					if (cell_adv) begin
						if (c_q + DW'(1) >= cols) begin
							c_q <= '0;
							r_q <= r_q + DW'(1);
						end else c_q <= c_q + DW'(1);
					end
				end
				ST_OUT: if (out_ready) begin
					r_q <= '0;
					c_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Output register fields.
	assign shape_found  = (best_len_q != '0);
	assign shape_length = best_len_q;
	assign start_row    = shape_found ? CRD_W'(br0_q) : '0;
	assign start_col    = shape_found ? CRD_W'(bc0_q) : '0;
	assign end_row      = shape_found ? CRD_W'(br1_q) : '0;
	assign end_col      = shape_found ? CRD_W'(bc1_q) : '0;
endmodule
